### sv/cdq_pkg.sv
// cdq_pkg: shared constants, codes and structs of the circular deque unit
// used by every module of the block except cdq_ram, no dependencies

package cdq_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ID_W      = 32;
    localparam int FUNC_W    = 3;
    localparam int OUTCOME_W = 2;
    localparam int IDX_W     = 4;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_REAR  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_REAR   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_STATUS     = 3'd4
    } func_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_DONE  = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_EMPTY = 2'd2
    } outcome_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        outcome_t           outcome;
        logic               removed_valid;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
        logic               front_at_first_slot;
        logic               rear_at_last_slot;
        logic [IDX_W-1:0]   front_index;
        logic [IDX_W-1:0]   rear_index;
    } status_t;

    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [ID_W-1:0]    wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic               load;
        logic               from_ram;
        status_t            status;
    } load_t;

endpackage

### sv/cdq_ram.sv
// cdq_ram: generic single write port, single read port synchronous ram
// read data registered when re is high, no dependencies

module cdq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/cdq_ctrl.sv
// cdq_ctrl: front and rear pointers, occupancy count and transaction sequencing
// depends on cdq_pkg

module cdq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [cdq_pkg::FUNC_W-1:0] in_func,
    input  logic [cdq_pkg::ID_W-1:0]  in_id,
    input  logic                      out_free,
    output logic                      in_ready,
    output cdq_pkg::mem_req_t         mem_req,
    output cdq_pkg::load_t            ld
);

    localparam logic [cdq_pkg::PTR_W-1:0] LAST_SLOT = cdq_pkg::PTR_W'(cdq_pkg::DEPTH - 1);

    function automatic logic [cdq_pkg::PTR_W-1:0] ptr_inc(input logic [cdq_pkg::PTR_W-1:0] p);
        ptr_inc = (p == LAST_SLOT) ? '0 : p + cdq_pkg::PTR_W'(1);
    endfunction

    function automatic logic [cdq_pkg::PTR_W-1:0] ptr_dec(input logic [cdq_pkg::PTR_W-1:0] p);
        ptr_dec = (p == '0) ? LAST_SLOT : p - cdq_pkg::PTR_W'(1);
    endfunction

    cdq_pkg::state_t            state_reg, state_next;
    logic [cdq_pkg::PTR_W-1:0]  front_reg, front_next;
    logic [cdq_pkg::PTR_W-1:0]  rear_reg, rear_next;
    logic [cdq_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    cdq_pkg::status_t           pending_reg;
    cdq_pkg::status_t           status_now;
    cdq_pkg::mem_req_t          req_raw;
    cdq_pkg::outcome_t          outcome;
    cdq_pkg::func_t             func;
    logic                       accept;
    logic                       pop_ok;
    logic                       is_empty_n;

    assign func   = cdq_pkg::func_t'(in_func);
    assign accept = in_valid && in_ready;

    // pointer and count update
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        cnt_next   = cnt_reg;
        outcome    = cdq_pkg::OUT_DONE;
        pop_ok     = 1'b0;
        req_raw    = '0;
        req_raw.wdata = in_id;
        case (func)
            cdq_pkg::FUNC_PUSH_REAR, cdq_pkg::FUNC_PUSH_FRONT:
            begin
                if (cnt_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
                begin
                    outcome = cdq_pkg::OUT_FULL;
                end
                else
                begin
                    cnt_next   = cnt_reg + cdq_pkg::CNT_W'(1);
                    req_raw.we = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        front_next    = '0;
                        rear_next     = '0;
                        req_raw.waddr = '0;
                    end
                    else if (func == cdq_pkg::FUNC_PUSH_REAR)
                    begin
                        rear_next     = ptr_inc(rear_reg);
                        req_raw.waddr = rear_next;
                    end
                    else
                    begin
                        front_next    = ptr_dec(front_reg);
                        req_raw.waddr = front_next;
                    end
                end
            end
            cdq_pkg::FUNC_POP_REAR, cdq_pkg::FUNC_POP_FRONT:
            begin
                if (cnt_reg == '0)
                begin
                    outcome = cdq_pkg::OUT_EMPTY;
                end
                else
                begin
                    pop_ok     = 1'b1;
                    cnt_next   = cnt_reg - cdq_pkg::CNT_W'(1);
                    req_raw.re = 1'b1;
                    req_raw.raddr = (func == cdq_pkg::FUNC_POP_REAR) ? rear_reg : front_reg;
                    if (front_reg == rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else if (func == cdq_pkg::FUNC_POP_REAR)
                    begin
                        rear_next = ptr_dec(rear_reg);
                    end
                    else
                    begin
                        front_next = ptr_inc(front_reg);
                    end
                end
            end
            default:
            begin
                outcome = cdq_pkg::OUT_DONE;
            end
        endcase
    end

    // status after the transaction
    always_comb
    begin
        is_empty_n = (cnt_next == '0);
        status_now.outcome             = outcome;
        status_now.removed_valid       = pop_ok;
        status_now.occupancy           = cdq_pkg::OCC_W'(cnt_next);
        status_now.is_empty            = is_empty_n;
        status_now.is_full             = (cnt_next == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
        status_now.front_at_first_slot = !is_empty_n && (front_next == '0);
        status_now.rear_at_last_slot   = !is_empty_n && (rear_next == LAST_SLOT);
        status_now.front_index         = cdq_pkg::IDX_W'(front_next);
        status_now.rear_index          = cdq_pkg::IDX_W'(rear_next);
    end

    always_comb
    begin
        mem_req    = req_raw;
        mem_req.we = req_raw.we && accept;
        mem_req.re = req_raw.re && accept;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (accept && pop_ok)
                begin
                    state_next = cdq_pkg::S_READ;
                end
            end
            cdq_pkg::S_READ:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready    = 1'b0;
        ld.load     = 1'b0;
        ld.from_ram = 1'b0;
        ld.status   = status_now;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                in_ready = out_free;
                ld.load  = accept && !pop_ok;
            end
            cdq_pkg::S_READ:
            begin
                ld.load     = 1'b1;
                ld.from_ram = 1'b1;
                ld.status   = pending_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pop_ok)
        begin
            pending_reg <= status_now;
        end
    end

endmodule

### sv/circular_deque_unit.sv
// circular_deque_unit: top level of the circular deque, output register stage
// depends on cdq_pkg, cdq_ctrl and cdq_ram

// A double-ended queue of 32-bit identifiers held in a 16-slot ram. Each
// input transaction is one of push rear, push front, pop rear, pop front or
// status query, and produces exactly one result transaction with the outcome,
// the removed identifier and the occupancy and pointer status after the
// operation. A successful pop holds off the next transaction while the read
// state waits for the registered slot ram data; pushes, rejected pops and
// status queries do not. A result waiting in the output register does not
// block the next transaction as long as it is taken in the same cycle.

module circular_deque_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func [2:0], entry_id [34:3], zero [39:35]
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // outcome [1:0], removed_valid [2], removed_id [34:3], occupancy [39:35],
    // is_empty [40], is_full [41], front_at_first_slot [42],
    // rear_at_last_slot [43], front_index [47:44], rear_index [51:48], zero [55:52]
    output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata
);

    cdq_pkg::mem_req_t          mem_req;
    cdq_pkg::load_t             ld;
    cdq_pkg::status_t           status_reg;
    logic [cdq_pkg::ID_W-1:0]   ram_rdata;
    logic [cdq_pkg::ID_W-1:0]   removed_id_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic                       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tdata[cdq_pkg::FUNC_W-1:0]),
        .in_id    (s_tdata[cdq_pkg::FUNC_W +: cdq_pkg::ID_W]),
        .out_free (out_free),
        .in_ready (s_tready),
        .mem_req  (mem_req),
        .ld       (ld)
    );

    cdq_ram #(
        .DATA_W (cdq_pkg::ID_W),
        .DEPTH  (cdq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (ld.load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            status_reg     <= ld.status;
            removed_id_reg <= ld.from_ram ? ram_rdata : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000,
                       status_reg.rear_index,
                       status_reg.front_index,
                       status_reg.rear_at_last_slot,
                       status_reg.front_at_first_slot,
                       status_reg.is_full,
                       status_reg.is_empty,
                       status_reg.occupancy,
                       removed_id_reg,
                       status_reg.removed_valid,
                       status_reg.outcome};

endmodule

### sv/cdq_checker.sv
// cdq_checker: port-level assertions on the circular deque unit results
// depends on cdq_pkg, bound to circular_deque_unit

module cdq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cdq_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[40] == (m_tdata[39:35] == 5'd0)))
        else $error("empty flag disagrees with occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[41] == (m_tdata[39:35] == 5'(cdq_pkg::DEPTH))))
        else $error("full flag disagrees with occupancy");

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> (m_tdata[51:44] == 8'd0) && !m_tdata[42] && !m_tdata[43])
        else $error("empty deque reports nonzero indices");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> (m_tdata[34:3] == 32'd0))
        else $error("removed id without a pop");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);

### sim/circular_deque_unit_tb.sv
// circular_deque_unit_tb: self-checking testbench of the circular deque unit
// drives directed and random operation streams with stalls on both sides, checks every result transaction
// depends on cdq_pkg and circular_deque_unit
`timescale 1ns / 100ps

module circular_deque_unit_tb;

    localparam int RANDOM_OPS  = 1000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 150;

    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    localparam logic [cdq_pkg::ID_W-1:0] ID_MIN  = 32'h8000_0000;
    localparam logic [cdq_pkg::ID_W-1:0] ID_MAX  = 32'h7FFF_FFFF;
    localparam logic [cdq_pkg::ID_W-1:0] ID_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0]                 pad;
        logic [cdq_pkg::ID_W-1:0]   entry_id;
        logic [cdq_pkg::FUNC_W-1:0] func;
    } deque_op_t;

    typedef struct packed {
        logic [3:0]                 pad;
        logic [cdq_pkg::IDX_W-1:0]  rear_index;
        logic [cdq_pkg::IDX_W-1:0]  front_index;
        logic                       rear_at_last_slot;
        logic                       front_at_first_slot;
        logic                       is_full;
        logic                       is_empty;
        logic [cdq_pkg::OCC_W-1:0]  occupancy;
        logic [cdq_pkg::ID_W-1:0]   removed_id;
        logic                       removed_valid;
        cdq_pkg::outcome_t          outcome;
    } deque_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cdq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cdq_pkg::M_TDATA_W-1:0] m_tdata;

    deque_op_t     pending_ops[$];
    deque_result_t expected_results[$];

    // predictor state
    logic [cdq_pkg::ID_W-1:0] id_store[cdq_pkg::DEPTH];
    int              front_slot = 0;
    int              rear_slot = 0;
    bit              deque_void = 1'b1;

    logic in_fire = 1'b0;
    logic hold_rx = 1'b0;
    int   items_in = 0;
    int   total_items = 0;
    int   quiet_from = 0;
    int   errors = 0;
    int   cycles = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 10;
    bit   quiet;

    assign quiet = (total_items > 0) && (items_in >= quiet_from);

    circular_deque_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int held_count();
        if (deque_void)
            return 0;
        if (rear_slot >= front_slot)
            return rear_slot - front_slot + 1;
        return cdq_pkg::DEPTH - front_slot + rear_slot + 1;
    endfunction

    function automatic deque_result_t predict_deque(deque_op_t op);
        deque_result_t r;
        int held;
        r = '0;
        r.outcome = cdq_pkg::OUT_DONE;
        held = held_count();
        if (op.func == cdq_pkg::FUNC_PUSH_REAR || op.func == cdq_pkg::FUNC_PUSH_FRONT)
        begin
            if (held == cdq_pkg::DEPTH)
                r.outcome = cdq_pkg::OUT_FULL;
            else if (deque_void)
            begin
                front_slot = 0;
                rear_slot = 0;
                deque_void = 1'b0;
                id_store[0] = op.entry_id;
            end
            else if (op.func == cdq_pkg::FUNC_PUSH_REAR)
            begin
                rear_slot = (rear_slot + 1) % cdq_pkg::DEPTH;
                id_store[rear_slot] = op.entry_id;
            end
            else
            begin
                front_slot = (front_slot + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                id_store[front_slot] = op.entry_id;
            end
        end
        else if (op.func == cdq_pkg::FUNC_POP_REAR || op.func == cdq_pkg::FUNC_POP_FRONT)
        begin
            if (deque_void)
                r.outcome = cdq_pkg::OUT_EMPTY;
            else
            begin
                r.removed_valid = 1'b1;
                r.removed_id = (op.func == cdq_pkg::FUNC_POP_REAR) ? id_store[rear_slot]
                                                                   : id_store[front_slot];
                // last entry gone: pointers back to slot 0
                if (front_slot == rear_slot)
                begin
                    front_slot = 0;
                    rear_slot = 0;
                    deque_void = 1'b1;
                end
                else if (op.func == cdq_pkg::FUNC_POP_REAR)
                    rear_slot = (rear_slot + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                else
                    front_slot = (front_slot + 1) % cdq_pkg::DEPTH;
            end
        end
        held = held_count();
        r.occupancy = cdq_pkg::OCC_W'(held);
        r.is_empty = deque_void;
        r.is_full = (held == cdq_pkg::DEPTH);
        r.front_at_first_slot = !deque_void && front_slot == 0;
        r.rear_at_last_slot = !deque_void && rear_slot == cdq_pkg::DEPTH - 1;
        r.front_index = deque_void ? '0 : cdq_pkg::IDX_W'(front_slot);
        r.rear_index = deque_void ? '0 : cdq_pkg::IDX_W'(rear_slot);
        return r;
    endfunction

    function automatic void flag_error(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0h, actual %0h", what, want, got);
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            flag_error(what, want, got);
    endfunction

    function automatic void check_result(deque_result_t got);
        deque_result_t want;
        if (expected_results.size() == 0)
        begin
            flag_error("unexpected result transaction", '0, 64'(got));
            return;
        end
        want = expected_results.pop_front();
        check_field("outcome", 64'(want.outcome), 64'(got.outcome));
        check_field("removed_valid", 64'(want.removed_valid), 64'(got.removed_valid));
        check_field("removed_id", 64'(want.removed_id), 64'(got.removed_id));
        check_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
        check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
        check_field("is_full", 64'(want.is_full), 64'(got.is_full));
        check_field("front_at_first_slot", 64'(want.front_at_first_slot),
                    64'(got.front_at_first_slot));
        check_field("rear_at_last_slot", 64'(want.rear_at_last_slot),
                    64'(got.rear_at_last_slot));
        check_field("front_index", 64'(want.front_index), 64'(got.front_index));
        check_field("rear_index", 64'(want.rear_index), 64'(got.rear_index));
        check_field("zero fill", 64'(want.pad), 64'(got.pad));
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    function automatic void add_op(logic [cdq_pkg::FUNC_W-1:0] f, logic [cdq_pkg::ID_W-1:0] id);
        deque_op_t op;
        op = '0;
        op.func = f;
        op.entry_id = id;
        pending_ops.push_back(op);
    endfunction

    function automatic logic [cdq_pkg::ID_W-1:0] random_id();
        case ($urandom_range(0, 15))
            0: return ID_MIN;
            1: return ID_MAX;
            2: return ID_ONES;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if ($urandom_range(0, 63) == 0)
                tx_idle_pct <= pick_idle_pct();
            if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
                s_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
            begin
                tx_gap <= $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata <= pending_ops.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            rx_idle_pct <= pick_idle_pct();
        if (!rst_n || hold_rx)
            m_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < rx_idle_pct)
        begin
            rx_gap <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        if (m_tvalid && m_tready)
            check_result(m_tdata);
        if (s_tvalid && s_tready)
        begin
            expected_results.push_back(predict_deque(s_tdata));
            items_in++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (items_in >= HOLD_AFTER);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        int mode;
        int pick;

        // directed: empty rejects, fill with extremes, full rejects, spare codes
        add_op(cdq_pkg::FUNC_STATUS, ID_ONES);
        add_op(cdq_pkg::FUNC_POP_REAR, ID_ONES);
        add_op(cdq_pkg::FUNC_POP_FRONT, ID_MIN);
        for (int k = 0; k < cdq_pkg::DEPTH; k++)
        begin
            case (k % 4)
                0: add_op(k % 2 ? cdq_pkg::FUNC_PUSH_FRONT : cdq_pkg::FUNC_PUSH_REAR, ID_MAX);
                1: add_op(cdq_pkg::FUNC_PUSH_FRONT, ID_MIN);
                2: add_op(cdq_pkg::FUNC_PUSH_REAR, ID_ONES);
                default: add_op(cdq_pkg::FUNC_PUSH_FRONT, cdq_pkg::ID_W'(k));
            endcase
        end
        add_op(cdq_pkg::FUNC_PUSH_REAR, 32'h1234_5678);
        add_op(cdq_pkg::FUNC_PUSH_FRONT, ID_MAX);
        add_op(FUNC_SPARE_5, ID_ONES);
        add_op(FUNC_SPARE_6, '0);
        add_op(FUNC_SPARE_7, ID_MIN);
        add_op(cdq_pkg::FUNC_POP_REAR, '0);
        add_op(cdq_pkg::FUNC_POP_FRONT, '0);

        // random: fill, drain and balanced stretches so both ends get hit often
        mode = 0;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 32 == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                add_op(pick < 6 ? cdq_pkg::FUNC_STATUS
                                : cdq_pkg::FUNC_W'($urandom_range(5, 7)),
                       random_id());
            else if ((mode == 0 && pick < 78) || (mode == 1 && pick < 28)
                     || (mode == 2 && pick < 54))
                add_op($urandom_range(0, 1) ? cdq_pkg::FUNC_PUSH_FRONT
                                            : cdq_pkg::FUNC_PUSH_REAR,
                       random_id());
            else
                add_op($urandom_range(0, 1) ? cdq_pkg::FUNC_POP_FRONT
                                            : cdq_pkg::FUNC_POP_REAR,
                       random_id());
        end

        quiet_from = pending_ops.size() - pending_ops.size() / 10;
        total_items = pending_ops.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_in == total_items);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("results missing: %0d", expected_results.size());
            errors += expected_results.size();
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque_unit.sv
sv/cdq_checker.sv
sim/circular_deque_unit_tb.sv
